/* hdl/bmalloc_pkg.sv */
package bmalloc_pkg;

	localparam int unsigned ACTION_W  = 2;
	localparam int unsigned INDEX_W   = 9;
	localparam int unsigned COUNT_W   = 9;
	localparam int unsigned LIMIT_W   = 9;
	localparam int unsigned S_TDATA_W = 16;
	localparam int unsigned M_TDATA_W = 24;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd256;

	typedef enum logic [ACTION_W-1:0] {
		ACT_SET      = 2'd0,
		ACT_CLR      = 2'd1,
		ACT_FIND_SET = 2'd2,
		ACT_FIND_CLR = 2'd3
	} action_t;

	localparam logic STAT_OK  = 1'b0;
	localparam logic STAT_OOB = 1'b1;

	typedef enum logic [6:0] {
		ST_CLEAR = 7'b0000001,
		ST_IDLE  = 7'b0000010,
		ST_ADDR  = 7'b0000100,
		ST_BIT   = 7'b0001000,
		ST_RMW   = 7'b0010000,
		ST_SCAN  = 7'b0100000,
		ST_DONE  = 7'b1000000
	} state_t;

endpackage

/* hdl/bitmap_allocator.sv */
// Bitmap allocator: keeps a map of MAX_BITS bits (numbered from 1) in a memory of
// WORD_BITS-bit words with one read and one write port, plus a count of set bits.
// A transaction sets a bit, clears a bit, or finds the lowest set or clear bit at
// or below the programmed limit, and returns one result with status, found index,
// count and full flag. The block takes one transaction at a time. Set and clear
// pass through the index-to-word multiply, bit offset, read-modify-write and result
// states. A find reads the memory one word per cycle from a registered read port,
// checking each word while the next is read, and stops at the first hit or at the
// limit. After reset a clearing pass zeroes all ceil(MAX_BITS / WORD_BITS) words
// (32 by default), one word per cycle, before the first transaction is taken; limit
// writes are taken throughout.
module bitmap_allocator #(
	parameter int unsigned MAX_BITS  = 256,
	parameter int unsigned WORD_BITS = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// limit register
	input  logic                                cfg_we,
	input  logic [bmalloc_pkg::LIMIT_W-1:0]     cfg_wdata,
	// request: tuser = action[1:0]; tdata = bit_index[8:0], zero padded
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [bmalloc_pkg::ACTION_W-1:0]    s_tuser,
	input  logic [bmalloc_pkg::S_TDATA_W-1:0]   s_tdata,
	// result: tuser = status[0]; tdata = found_index[8:0], set_count[17:9],
	// is_full[18], zero padded
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic                                m_tuser,
	output logic [bmalloc_pkg::M_TDATA_W-1:0]   m_tdata
);
	import bmalloc_pkg::*;

	localparam int unsigned NUM_WORDS = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
	localparam int unsigned AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
	localparam int unsigned BB        = $clog2(WORD_BITS);
	localparam int unsigned BW        = $clog2(MAX_BITS + 2 * WORD_BITS);
	localparam int unsigned SAT       = (MAX_BITS > 511) ? 511 : MAX_BITS;
	// floor(pos / WORD_BITS) as (pos * RECIP) >> 16, exact for pos < 512
	localparam int unsigned RECIP     = (65536 + WORD_BITS - 1) / WORD_BITS;
	localparam int unsigned PW        = 27;

	state_t                 state_q;
	action_t                action_q;
	logic [LIMIT_W-1:0]     limit_q;
	logic [LIMIT_W-1:0]     lim;
	logic [COUNT_W-1:0]     count_q;
	logic [INDEX_W-1:0]     pos_q;
	logic [AW-1:0]          word_q;
	logic [BB-1:0]          bit_q;
	logic [AW-1:0]          addr_q;
	logic [BW-1:0]          iss_base_q;
	logic [BW-1:0]          chk_base_s1;
	logic                   chk_vld_s1;
	logic                   res_status_q;
	logic [INDEX_W-1:0]     res_found_q;

	logic                   m_tvalid_q;
	logic                   out_status_q;
	logic [INDEX_W-1:0]     out_found_q;
	logic [COUNT_W-1:0]     out_count_q;
	logic                   out_full_q;

	logic [WORD_BITS-1:0]   mem [NUM_WORDS];
	logic [WORD_BITS-1:0]   rd_q;
	logic [AW-1:0]          rd_addr;
	logic                   wr_en;
	logic [AW-1:0]          wr_addr;
	logic [WORD_BITS-1:0]   wr_data;

	logic [INDEX_W-1:0]     in_index;
	action_t                in_action;
	logic                   in_oob;
	logic [PW-1:0]          prod;
	logic [15:0]            offs;
	logic                   cur_bit;
	logic [WORD_BITS-1:0]   hit_vec;
	logic                   hit_any;
	logic [BB-1:0]          hit_pos;
	logic                   scan_last;
	logic                   want;
	logic                   out_free;

	assign in_index  = s_tdata[INDEX_W-1:0];
	assign in_action = action_t'(s_tuser);
	assign lim       = (limit_q > LIMIT_W'(SAT)) ? LIMIT_W'(SAT) : limit_q;
	assign in_oob    = (in_index == '0) || (in_index > lim);
	assign s_tready  = (state_q == ST_IDLE);
	assign out_free  = !m_tvalid_q || m_tready;

	assign prod    = PW'(pos_q) * PW'(RECIP);
	assign offs    = 16'(pos_q) - 16'(word_q) * 16'(WORD_BITS);
	assign cur_bit = rd_q[bit_q];
	assign want    = (action_q == ACT_FIND_SET);

	// mask bits at or above the limit, then pick the lowest match
	always_comb begin
		for (int j = 0; j < WORD_BITS; j++) begin
			hit_vec[j] = ((chk_base_s1 + BW'(j)) < BW'(lim)) && (rd_q[j] == want);
		end
		hit_pos = '0;
		for (int j = WORD_BITS - 1; j >= 0; j--) begin
			if (hit_vec[j]) begin
				hit_pos = BB'(j);
			end
		end
	end
	assign hit_any   = |hit_vec;
	assign scan_last = (chk_base_s1 + BW'(WORD_BITS)) >= BW'(lim);

	always_comb begin
		rd_addr = (state_q == ST_SCAN) ? addr_q : word_q;
		wr_en   = 1'b0;
		wr_addr = word_q;
		wr_data = rd_q;
		case (state_q)
			ST_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = addr_q;
				wr_data = '0;
			end
			ST_RMW: begin
				wr_en          = 1'b1;
				wr_data[bit_q] = (action_q == ACT_SET);
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			limit_q      <= LIMIT_RESET;
			count_q      <= '0;
			addr_q       <= '0;
			chk_vld_s1   <= 1'b0;
			m_tvalid_q   <= 1'b0;
			action_q     <= ACT_SET;
			res_status_q <= STAT_OK;
			res_found_q  <= '0;
		end else begin
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			if (state_q == ST_DONE && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					if (addr_q == AW'(NUM_WORDS - 1)) begin
						addr_q  <= '0;
						state_q <= ST_IDLE;
					end else begin
						addr_q <= addr_q + AW'(1);
					end
				end
				ST_IDLE: begin
					if (s_tvalid) begin
						action_q     <= in_action;
						res_found_q  <= '0;
						res_status_q <= STAT_OK;
						addr_q       <= '0;
						iss_base_q   <= '0;
						chk_vld_s1   <= 1'b0;
						pos_q        <= in_index - INDEX_W'(1);
						if (in_action == ACT_SET || in_action == ACT_CLR) begin
							if (in_oob) begin
								res_status_q <= STAT_OOB;
								state_q      <= ST_DONE;
							end else begin
								state_q <= ST_ADDR;
							end
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_ADDR: begin
					word_q  <= prod[16 +: AW];
					state_q <= ST_BIT;
				end
				ST_BIT: begin
					bit_q   <= offs[BB-1:0];
					state_q <= ST_RMW;
				end
				ST_RMW: begin
					if (action_q == ACT_SET && !cur_bit) begin
						count_q <= count_q + COUNT_W'(1);
					end else if (action_q == ACT_CLR && cur_bit) begin
						count_q <= count_q - COUNT_W'(1);
					end
					state_q <= ST_DONE;
				end
				ST_SCAN: begin
					// issue the next word while checking the one read last cycle
					chk_vld_s1  <= 1'b1;
					chk_base_s1 <= iss_base_q;
					if (addr_q != AW'(NUM_WORDS - 1)) begin
						addr_q     <= addr_q + AW'(1);
						iss_base_q <= iss_base_q + BW'(WORD_BITS);
					end
					if (chk_vld_s1) begin
						if (hit_any) begin
							res_found_q <= INDEX_W'(chk_base_s1 + BW'(hit_pos) + BW'(1));
							state_q     <= ST_DONE;
						end else if (scan_last) begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			out_status_q <= res_status_q;
			out_found_q  <= res_found_q;
			out_count_q  <= count_q;
			out_full_q   <= (count_q == lim);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {5'b0, out_full_q, out_count_q, out_found_q};

	a_count_only_in_rmw: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_RMW) |=> (count_q == $past(count_q)))
		else $error("set count changed outside read-modify-write");

	a_oob_no_found: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata[INDEX_W-1:0] == '0))
		else $error("out-of-bounds result carries a found index");

	a_found_in_limit: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[INDEX_W-1:0] <= lim))
		else $error("found index above limit");

	a_done_holds_output: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && m_tvalid && !m_tready) |=> (state_q == ST_DONE))
		else $error("result overwrote an untaken output");

endmodule
